@@ rtl/cgcs_pkg.sv @@
package cgcs_pkg;

    // Grid geometry
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CFG_DIM_W = DIM_W + 1;
    localparam int STEP_W    = $clog2(DIM_W + 1);

    // Cost and color arithmetic
    localparam int COST_W     = 8;
    localparam int COLOR_BITS = 8;
    localparam int CH_MAX     = (1 << COLOR_BITS) - 1;
    localparam int SPAN_W     = COST_W;
    localparam int SPAN_MAX   = (1 << SPAN_W) - 1;
    localparam int W_W        = SPAN_W + 2;
    localparam int ANCHOR_W   = 7;
    localparam int ANCHOR_MAX = 95;
    localparam int V_W        = $clog2(ANCHOR_MAX * SPAN_MAX + 1);
    localparam longint NUM_MAX = longint'(2 * CH_MAX) * ANCHOR_MAX * SPAN_MAX
                                 + 100 * SPAN_MAX;
    localparam int NUM_W      = $clog2(NUM_MAX + 1);
    localparam int DEN_W      = $clog2(200 * SPAN_MAX + 1);
    localparam int Q_W        = COLOR_BITS;
    localparam int QCNT_W     = $clog2(Q_W);
    localparam int ALPHA_W    = 8;

    // Register file
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_STRIDE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COST_LOW       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COST_HIGH      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_UNKNOWN_EN     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE_PASTEL = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OPACITY        = 3'd7;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] width;
        logic [CFG_DIM_W-1:0] height;
        logic [CFG_DIM_W-1:0] stride;
    } geom_cfg_t;

    typedef struct packed {
        logic             done;
        logic             on_grid;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
    } rast_status_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [COST_W-1:0] cost_low;
        logic [COST_W-1:0] cost_high;
        logic              unknown;
        logic              pastel;
    } color_req_t;

    typedef struct packed {
        logic                  done;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } color_res_t;

endpackage

@@ rtl/cost_grid_colormap_sampler.sv @@
// Cost grid color-map sampler: one cell word is taken, then the block is busy.
// The next cell is taken only once the current one is done, paced by the 12-step bit-serial
// stride remainder on the column and row counters; the three 8-step color dividers finish
// before it does. A result waits in the output register and stalls only the next cell's
// completion.
// Reset (aresetn low, synchronous) clears the raster counters, loads the register defaults.
module cost_grid_colormap_sampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Cell input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cgcs_pkg::COST_W-1:0]     s_cost,
    // Result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cgcs_pkg::DIM_W-1:0]      m_cell_col,
    output logic [cgcs_pkg::DIM_W-1:0]      m_cell_row,
    output logic [cgcs_pkg::COLOR_BITS-1:0] m_red,
    output logic [cgcs_pkg::COLOR_BITS-1:0] m_green,
    output logic [cgcs_pkg::COLOR_BITS-1:0] m_blue,
    output logic [cgcs_pkg::ALPHA_W-1:0]    m_alpha,
    output logic                            m_is_unknown,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cgcs_pkg::ADDR_W-1:0]     paddr,
    input  logic [cgcs_pkg::DATA_W-1:0]     pwdata,
    output logic [cgcs_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import cgcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [CFG_DIM_W-1:0]  grid_width_reg, grid_height_reg, sample_stride_reg;
    logic [COST_W-1:0]     cost_low_reg, cost_high_reg;
    logic                  unknown_en_reg, palette_pastel_reg;
    logic [ALPHA_W-1:0]    opacity_reg;
    logic [CFG_DIM_W-1:0]  dim_wr, stride_wr;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    logic [1:0]            state_reg, state_next;
    logic                  accept, unknown_reg, keep, units_done, out_free, load_out;
    geom_cfg_t             geom;
    rast_status_t          rast;
    color_req_t            creq;
    color_res_t            cres;

    logic                  m_valid_reg;
    logic [DIM_W-1:0]      col_out_reg, row_out_reg;
    logic [COLOR_BITS-1:0] red_reg, green_reg, blue_reg;
    logic [ALPHA_W-1:0]    alpha_reg;
    logic                  unknown_out_reg;

    // Register writes; dimensions clamp to 1..MAX_DIM, the stride to at least 1.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        dim_wr    = pwdata[CFG_DIM_W-1:0];
        stride_wr = pwdata[CFG_DIM_W-1:0];
        if (dim_wr == '0) begin
            dim_wr = CFG_DIM_W'(1);
        end else if (dim_wr > CFG_DIM_W'(MAX_DIM)) begin
            dim_wr = CFG_DIM_W'(MAX_DIM);
        end
        if (stride_wr == '0) begin
            stride_wr = CFG_DIM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg     <= CFG_DIM_W'(1);
            grid_height_reg    <= CFG_DIM_W'(1);
            sample_stride_reg  <= CFG_DIM_W'(1);
            cost_low_reg       <= COST_W'(0);
            cost_high_reg      <= COST_W'(100);
            unknown_en_reg     <= 1'b0;
            palette_pastel_reg <= 1'b0;
            opacity_reg        <= ALPHA_W'(89);
        end else if (wr_en) begin
            case (reg_idx)
                REG_GRID_WIDTH:     grid_width_reg     <= dim_wr;
                REG_GRID_HEIGHT:    grid_height_reg    <= dim_wr;
                REG_SAMPLE_STRIDE:  sample_stride_reg  <= stride_wr;
                REG_COST_LOW:       cost_low_reg       <= pwdata[COST_W-1:0];
                REG_COST_HIGH:      cost_high_reg      <= pwdata[COST_W-1:0];
                REG_UNKNOWN_EN:     unknown_en_reg     <= pwdata[0];
                REG_PALETTE_PASTEL: palette_pastel_reg <= pwdata[0];
                REG_OPACITY:        opacity_reg        <= pwdata[ALPHA_W-1:0];
                default:            ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_GRID_WIDTH:     prdata = DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT:    prdata = DATA_W'(grid_height_reg);
            REG_SAMPLE_STRIDE:  prdata = DATA_W'(sample_stride_reg);
            REG_COST_LOW:       prdata = DATA_W'(cost_low_reg);
            REG_COST_HIGH:      prdata = DATA_W'(cost_high_reg);
            REG_UNKNOWN_EN:     prdata = DATA_W'(unknown_en_reg);
            REG_PALETTE_PASTEL: prdata = DATA_W'(palette_pastel_reg);
            REG_OPACITY:        prdata = DATA_W'(opacity_reg);
            default:            prdata = '0;
        endcase
    end

    // Raster position and color run side by side on each accepted word.
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign geom.width  = grid_width_reg;
    assign geom.height = grid_height_reg;
    assign geom.stride = sample_stride_reg;

    assign creq.cost      = s_cost;
    assign creq.cost_low  = cost_low_reg;
    assign creq.cost_high = cost_high_reg;
    assign creq.unknown   = s_cost[COST_W-1];
    assign creq.pastel    = palette_pastel_reg;

    cgcs_raster u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .geom    (geom),
        .status  (rast)
    );

    cgcs_color u_color (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .req     (creq),
        .res     (cres)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            unknown_reg <= s_cost[COST_W-1];
        end
    end

    // Sequencer: wait for both units, then drop the cell or hand it to the output register.
    assign units_done = rast.done && cres.done;
    assign keep       = rast.on_grid && (!unknown_reg || unknown_en_reg);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (units_done) begin
                    if (!keep) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            col_out_reg     <= rast.col;
            row_out_reg     <= rast.row;
            red_reg         <= cres.red;
            green_reg       <= cres.green;
            blue_reg        <= cres.blue;
            alpha_reg       <= opacity_reg;
            unknown_out_reg <= unknown_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_col   = col_out_reg;
    assign m_cell_row   = row_out_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_alpha      = alpha_reg;
    assign m_is_unknown = unknown_out_reg;

endmodule

@@ rtl/cgcs_raster.sv @@
module cgcs_raster (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  cgcs_pkg::geom_cfg_t    geom,
    output cgcs_pkg::rast_status_t status
);
    import cgcs_pkg::*;

    logic [DIM_W-1:0]     column_count_reg, column_count_next;
    logic [DIM_W-1:0]     row_count_reg, row_count_next;
    logic [CFG_DIM_W-1:0] col_inc, row_inc;
    logic [DIM_W-1:0]     col_cap_reg, row_cap_reg;
    logic [DIM_W-1:0]     col_sh_reg, row_sh_reg;
    logic [DIM_W-1:0]     col_rem_reg, row_rem_reg;
    logic [CFG_DIM_W-1:0] col_trial, row_trial;
    logic [STEP_W-1:0]    step_reg;
    logic                 active_reg, done_reg;

    // Raster advance: the column wraps at the width, the row at the height.
    always_comb begin
        col_inc = {1'b0, column_count_reg} + CFG_DIM_W'(1);
        row_inc = {1'b0, row_count_reg} + CFG_DIM_W'(1);
        column_count_next = col_inc[DIM_W-1:0];
        row_count_next    = row_count_reg;
        if (col_inc >= geom.width) begin
            column_count_next = '0;
            if (row_inc >= geom.height) begin
                row_count_next = '0;
            end else begin
                row_count_next = row_inc[DIM_W-1:0];
            end
        end
    end

    // One remainder step per cycle: shift in the next counter bit, subtract the stride if it fits.
    assign col_trial = {col_rem_reg, col_sh_reg[DIM_W-1]};
    assign row_trial = {row_rem_reg, row_sh_reg[DIM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            active_reg       <= 1'b0;
            done_reg         <= 1'b0;
            step_reg         <= '0;
        end else if (start) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            col_cap_reg      <= column_count_reg;
            row_cap_reg      <= row_count_reg;
            col_sh_reg       <= column_count_reg;
            row_sh_reg       <= row_count_reg;
            col_rem_reg      <= '0;
            row_rem_reg      <= '0;
            step_reg         <= '0;
            active_reg       <= 1'b1;
            done_reg         <= 1'b0;
        end else if (active_reg) begin
            col_sh_reg <= col_sh_reg << 1;
            row_sh_reg <= row_sh_reg << 1;
            if (col_trial >= geom.stride) begin
                col_rem_reg <= DIM_W'(col_trial - geom.stride);
            end else begin
                col_rem_reg <= col_trial[DIM_W-1:0];
            end
            if (row_trial >= geom.stride) begin
                row_rem_reg <= DIM_W'(row_trial - geom.stride);
            end else begin
                row_rem_reg <= row_trial[DIM_W-1:0];
            end
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIM_W - 1)) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    assign status.done    = done_reg;
    assign status.on_grid = (col_rem_reg == '0) && (row_rem_reg == '0);
    assign status.col     = col_cap_reg;
    assign status.row     = row_cap_reg;

endmodule

@@ rtl/cgcs_divider.sv @@
module cgcs_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [cgcs_pkg::NUM_W-1:0] num,
    input  logic [cgcs_pkg::DEN_W-1:0] den,
    output logic [cgcs_pkg::Q_W-1:0]   quot,
    output logic                       done
);
    import cgcs_pkg::*;

    logic [NUM_W-1:0]  rem_reg, dsh_reg;
    logic [Q_W-1:0]    quot_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              active_reg, done_reg;
    logic              fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else if (start) begin
            rem_reg    <= num;
            dsh_reg    <= NUM_W'(den) << (Q_W - 1);
            quot_reg   <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
        end else if (active_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[Q_W-2:0], fits};
            cnt_reg  <= cnt_reg + QCNT_W'(1);
            if (cnt_reg == QCNT_W'(Q_W - 1)) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

@@ rtl/cgcs_color.sv @@
module cgcs_color (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  cgcs_pkg::color_req_t req,
    output cgcs_pkg::color_res_t res
);
    import cgcs_pkg::*;

    // Palette anchors in hundredths, red, green, blue.
    localparam logic [ANCHOR_W-1:0] P_LO  [3] = '{7'd72, 7'd86, 7'd95};
    localparam logic [ANCHOR_W-1:0] P_HI  [3] = '{7'd95, 7'd80, 7'd86};
    localparam logic [ANCHOR_W-1:0] S_LO  [3] = '{7'd20, 7'd70, 7'd95};
    localparam logic [ANCHOR_W-1:0] S_MID [3] = '{7'd20, 7'd85, 7'd35};
    localparam logic [ANCHOR_W-1:0] S_HI  [3] = '{7'd92, 7'd16, 7'd14};
    localparam logic [ANCHOR_W-1:0] G_S   [3] = '{7'd20, 7'd20, 7'd20};
    localparam logic [ANCHOR_W-1:0] G_P   [3] = '{7'd85, 7'd85, 7'd88};
    localparam int PROD_W = ANCHOR_W + W_W;

    logic signed [COST_W:0] span_diff, cost_diff;
    logic [SPAN_W-1:0]      span_c, n_c;
    logic [W_W-1:0]         span_w, n_w, two_n, w0_c, w1_c;
    logic [ANCHOR_W-1:0]    a_c [3];
    logic [ANCHOR_W-1:0]    b_c [3];

    logic [SPAN_W-1:0]      span_reg;
    logic [W_W-1:0]         w0_reg, w1_reg;
    logic [ANCHOR_W-1:0]    a_reg [3];
    logic [ANCHOR_W-1:0]    b_reg [3];
    logic [V_W-1:0]         v_reg [3];
    logic [PROD_W:0]        v_sum [3];
    logic [NUM_W-1:0]       num [3];
    logic [DEN_W-1:0]       den;
    logic [Q_W-1:0]         quot [3];
    logic [2:0]             div_done;
    logic                   s1_reg, s2_reg;

    // Span, clamped offset and the two interpolation weights of the chosen segment.
    always_comb begin
        span_diff = $signed({req.cost_high[COST_W-1], req.cost_high})
                  - $signed({req.cost_low[COST_W-1], req.cost_low});
        cost_diff = $signed({req.cost[COST_W-1], req.cost})
                  - $signed({req.cost_low[COST_W-1], req.cost_low});
        span_c = (span_diff < $signed((COST_W+1)'(1))) ? SPAN_W'(1) : span_diff[SPAN_W-1:0];
        if (cost_diff[COST_W]) begin
            n_c = '0;
        end else if (cost_diff[SPAN_W-1:0] > span_c) begin
            n_c = span_c;
        end else begin
            n_c = cost_diff[SPAN_W-1:0];
        end
        span_w = W_W'(span_c);
        n_w    = W_W'(n_c);
        two_n  = n_w << 1;
        for (int c = 0; c < 3; c++) begin
            a_c[c] = S_MID[c];
            b_c[c] = S_HI[c];
        end
        if (req.unknown) begin
            // Grey is the low anchor at full weight.
            span_c = SPAN_W'(1);
            w0_c   = W_W'(1);
            w1_c   = '0;
            for (int c = 0; c < 3; c++) begin
                a_c[c] = req.pastel ? G_P[c] : G_S[c];
                b_c[c] = a_c[c];
            end
        end else if (req.pastel) begin
            w0_c = span_w - n_w;
            w1_c = n_w;
            for (int c = 0; c < 3; c++) begin
                a_c[c] = P_LO[c];
                b_c[c] = P_HI[c];
            end
        end else if (two_n < span_w) begin
            w0_c = span_w - two_n;
            w1_c = two_n;
            for (int c = 0; c < 3; c++) begin
                a_c[c] = S_LO[c];
                b_c[c] = S_MID[c];
            end
        end else begin
            w0_c = (span_w << 1) - two_n;
            w1_c = two_n - span_w;
        end
    end

    // Weighted anchor sum per channel, in hundredths times the span.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v_sum[c] = (PROD_W+1)'(PROD_W'(a_reg[c]) * PROD_W'(w0_reg))
                     + (PROD_W+1)'(PROD_W'(b_reg[c]) * PROD_W'(w1_reg));
        end
    end

    // Rounded scaling: (2*CH_MAX*v + 100*span) / (200*span).
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num[c] = NUM_W'(v_reg[c]) * NUM_W'(2 * CH_MAX) + NUM_W'(span_reg) * NUM_W'(100);
        end
        den = DEN_W'(span_reg) * DEN_W'(200);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= start;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            span_reg <= span_c;
            w0_reg   <= w0_c;
            w1_reg   <= w1_c;
            for (int c = 0; c < 3; c++) begin
                a_reg[c] <= a_c[c];
                b_reg[c] <= b_c[c];
            end
        end
        if (s1_reg) begin
            for (int c = 0; c < 3; c++) begin
                v_reg[c] <= v_sum[c][V_W-1:0];
            end
        end
    end

    // One serial divider per channel, all started together.
    for (genvar c = 0; c < 3; c++) begin : g_div
        cgcs_divider u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (s2_reg),
            .num     (num[c]),
            .den     (den),
            .quot    (quot[c]),
            .done    (div_done[c])
        );
    end

    assign res.done  = (&div_done) && !s1_reg && !s2_reg;
    assign res.red   = quot[0];
    assign res.green = quot[1];
    assign res.blue  = quot[2];

endmodule

@@ rtl/cgcs_checker.sv @@
module cgcs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [cgcs_pkg::DIM_W-1:0]      m_cell_col,
    input logic [cgcs_pkg::DIM_W-1:0]      m_cell_row,
    input logic [cgcs_pkg::COLOR_BITS-1:0] m_red,
    input logic [cgcs_pkg::COLOR_BITS-1:0] m_green,
    input logic [cgcs_pkg::COLOR_BITS-1:0] m_blue,
    input logic                            m_is_unknown
);

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_col) && $stable(m_cell_row)
                                && $stable(m_red) && $stable(m_green) && $stable(m_blue))
        else $error("result word changed while stalled");

    // One cell at a time: the input closes right after a word is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted a second word while busy");

    // Both unknown greys have equal red and green.
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_unknown |-> m_red == m_green)
        else $error("unknown cell colour is not grey");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cost_grid_colormap_sampler cgcs_checker u_cgcs_checker (.*);

@@ tb/tb_cost_grid_colormap_sampler.sv @@
module tb_cost_grid_colormap_sampler;
    import cgcs_pkg::*;

    // Palette anchor points, in hundredths of full scale.
    typedef enum int {
        HUE_SAFE_LO,
        HUE_SAFE_MID,
        HUE_SAFE_HI,
        HUE_PASTEL_LO,
        HUE_PASTEL_HI,
        HUE_GREY_SAFE,
        HUE_GREY_PASTEL
    } anchor_t;

    typedef struct packed {
        logic [DIM_W-1:0]      col;
        logic [DIM_W-1:0]      row;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [ALPHA_W-1:0]    alpha;
        logic                  unknown;
    } cell_color_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COST_W-1:0]     s_cost;
    logic                  m_valid;
    logic                  m_ready;
    logic [DIM_W-1:0]      m_cell_col;
    logic [DIM_W-1:0]      m_cell_row;
    logic [COLOR_BITS-1:0] m_red;
    logic [COLOR_BITS-1:0] m_green;
    logic [COLOR_BITS-1:0] m_blue;
    logic [ALPHA_W-1:0]    m_alpha;
    logic                  m_is_unknown;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Shadow of the register file and the raster position.
    int          grid_w;
    int          grid_h;
    int          stride;
    int          cost_lo;
    int          cost_hi;
    bit          unknown_en;
    bit          pastel;
    logic [7:0]  opacity;
    int          col_pos;
    int          row_pos;

    cell_color_t pending_colors[$];
    cell_color_t want;
    int          errors;
    int          burst_left;
    bit          steady;
    bit          ready_next;
    int          ready_hold;

    cost_grid_colormap_sampler dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cost       (s_cost),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_col   (m_cell_col),
        .m_cell_row   (m_cell_row),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_is_unknown (m_is_unknown),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int anchor(input anchor_t which, input int ch);
        logic [23:0] rgb;
        case (which)
            HUE_SAFE_LO:     rgb = {8'd20, 8'd70, 8'd95};
            HUE_SAFE_MID:    rgb = {8'd20, 8'd85, 8'd35};
            HUE_SAFE_HI:     rgb = {8'd92, 8'd16, 8'd14};
            HUE_PASTEL_LO:   rgb = {8'd72, 8'd86, 8'd95};
            HUE_PASTEL_HI:   rgb = {8'd95, 8'd80, 8'd86};
            HUE_GREY_SAFE:   rgb = {8'd20, 8'd20, 8'd20};
            default:         rgb = {8'd85, 8'd85, 8'd88};
        endcase
        return rgb[8*(2-ch) +: 8];
    endfunction

    // Scale a value in hundredths times den to a channel code, rounding half up.
    function automatic logic [COLOR_BITS-1:0] to_channel(input longint num, input longint den);
        longint d;
        d = 100 * den;
        return COLOR_BITS'((2 * CH_MAX * num + d) / (2 * d));
    endfunction

    function automatic int clamp_dim(input logic [12:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // Predict the color word for one cell and advance the raster position.
    function automatic bit colorize_cell(input logic [7:0] cost_bits, output cell_color_t res);
        int                    cost;
        int                    span;
        int                    n;
        int                    ch;
        longint                v;
        bit                    unknown;
        bit                    keep;
        logic [COLOR_BITS-1:0] rgb [0:2];
        cost = $signed(cost_bits);
        unknown = (cost < 0);
        keep = (col_pos % stride == 0) && (row_pos % stride == 0) && (!unknown || unknown_en);
        res = '0;
        if (keep) begin
            span = cost_hi - cost_lo;
            if (span < 1) span = 1;
            n = cost - cost_lo;
            if (n < 0) n = 0;
            if (n > span) n = span;
            for (ch = 0; ch < 3; ch++) begin
                if (unknown) begin
                    v = anchor(pastel ? HUE_GREY_PASTEL : HUE_GREY_SAFE, ch);
                    rgb[ch] = to_channel(v, 1);
                end else begin
                    if (pastel) begin
                        v = anchor(HUE_PASTEL_LO, ch) * (span - n) + anchor(HUE_PASTEL_HI, ch) * n;
                    end else if (2 * n < span) begin
                        v = anchor(HUE_SAFE_LO, ch) * (span - 2 * n)
                            + anchor(HUE_SAFE_MID, ch) * (2 * n);
                    end else begin
                        v = anchor(HUE_SAFE_MID, ch) * (2 * span - 2 * n)
                            + anchor(HUE_SAFE_HI, ch) * (2 * n - span);
                    end
                    rgb[ch] = to_channel(v, span);
                end
            end
            res.col = col_pos[DIM_W-1:0];
            res.row = row_pos[DIM_W-1:0];
            res.red = rgb[0];
            res.green = rgb[1];
            res.blue = rgb[2];
            res.alpha = opacity;
            res.unknown = unknown;
        end
        // Raster advance: a counter at or past its bound wraps on this step.
        col_pos++;
        if (col_pos >= grid_w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= grid_h) row_pos = 0;
        end
        return keep;
    endfunction

    // Register write: setup phase, then access phase, then the bus goes idle.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_GRID_WIDTH:     grid_w = clamp_dim(value[12:0]);
            REG_GRID_HEIGHT:    grid_h = clamp_dim(value[12:0]);
            REG_SAMPLE_STRIDE:  stride = (value[12:0] == 0) ? 1 : value[12:0];
            REG_COST_LOW:       cost_lo = $signed(value[7:0]);
            REG_COST_HIGH:      cost_hi = $signed(value[7:0]);
            REG_UNKNOWN_EN:     unknown_en = value[0];
            REG_PALETTE_PASTEL: pastel = value[0];
            default:            opacity = value[7:0];
        endcase
    endtask

    // Send one cell word and record its predicted color word, if any.
    task automatic send_cell(input logic [7:0] cost);
        cell_color_t res;
        s_valid <= 1'b1;
        s_cost <= cost;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (colorize_cell(cost, res)) pending_colors.insert(pending_colors.size(), res);
        // Bursts of random length with random gaps between them.
        if (steady || burst_left > 0) begin
            if (burst_left > 0) burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Stop sending and wait until every predicted word has come and the block is idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
        end
    endtask

    function automatic int extreme_dim();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 8191;
            2:       return 4096;
            default: return 4097;
        endcase
    endfunction

    // Reset defaults: a 1x1 grid and the safety palette over 0..100.
    task automatic test_reset_defaults();
        send_cell(8'sd0);
        send_cell(8'sd100);
        send_cell(8'sd49);
        send_cell(8'sd50);
        send_cell(8'sd127);
        send_cell(-8'sd1);
    endtask

    // Field extremes, both palettes, unknown gray and inverted ranges.
    task automatic test_palette_extremes();
        settle();
        write_reg(REG_GRID_WIDTH, 8);
        write_reg(REG_GRID_HEIGHT, 4);
        write_reg(REG_SAMPLE_STRIDE, 1);
        write_reg(REG_COST_LOW, -128);
        write_reg(REG_COST_HIGH, 127);
        write_reg(REG_UNKNOWN_EN, 1);
        write_reg(REG_PALETTE_PASTEL, 0);
        write_reg(REG_OPACITY, 255);
        send_cell(8'sd127);
        send_cell(8'sd0);
        send_cell(-8'sd1);
        send_cell(-8'sd128);
        // Equal bounds: span of one, low color at or below the bound.
        settle();
        write_reg(REG_PALETTE_PASTEL, 1);
        write_reg(REG_OPACITY, 0);
        write_reg(REG_COST_LOW, 50);
        write_reg(REG_COST_HIGH, 50);
        send_cell(8'sd50);
        send_cell(8'sd51);
        send_cell(-8'sd128);
        send_cell(8'sd127);
        // High bound below the low bound, unknown cells dropped.
        settle();
        write_reg(REG_PALETTE_PASTEL, 0);
        write_reg(REG_COST_LOW, 100);
        write_reg(REG_COST_HIGH, -100);
        write_reg(REG_UNKNOWN_EN, 0);
        send_cell(8'sd100);
        send_cell(8'sd127);
        send_cell(8'sd0);
        send_cell(-8'sd5);
    endtask

    // Shrink the grid while the counters sit beyond the new bounds.
    task automatic test_geometry_change();
        settle();
        write_reg(REG_GRID_WIDTH, 16);
        write_reg(REG_GRID_HEIGHT, 16);
        write_reg(REG_UNKNOWN_EN, 1);
        repeat (5) send_cell(8'($urandom_range(0, 255)));
        settle();
        write_reg(REG_GRID_WIDTH, 4);
        send_cell(8'sd20);
        settle();
        write_reg(REG_GRID_HEIGHT, 1);
        repeat (5) send_cell(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         items;
        int         lo;
        int         hi;
        int         r;
        logic [7:0] cost;
        sent = 0;
        while (sent < 1500) begin
            settle();
            r = $urandom_range(0, 9);
            write_reg(REG_GRID_WIDTH, (r == 0) ? extreme_dim() : $urandom_range(1, 12));
            r = $urandom_range(0, 9);
            write_reg(REG_GRID_HEIGHT, (r == 0) ? extreme_dim() : $urandom_range(1, 8));
            r = $urandom_range(0, 9);
            if (r < 7) write_reg(REG_SAMPLE_STRIDE, $urandom_range(1, 3));
            else if (r < 9) write_reg(REG_SAMPLE_STRIDE, $urandom_range(4, 8));
            else write_reg(REG_SAMPLE_STRIDE, extreme_dim());
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_COST_LOW, $urandom_range(0, 255));
                write_reg(REG_COST_HIGH, $urandom_range(0, 255));
            end else begin
                lo = $urandom_range(0, 228) - 128;
                write_reg(REG_COST_LOW, lo);
                write_reg(REG_COST_HIGH, lo + $urandom_range(1, 127 - lo));
            end
            write_reg(REG_UNKNOWN_EN, $urandom_range(0, 1));
            write_reg(REG_PALETTE_PASTEL, $urandom_range(0, 1));
            write_reg(REG_OPACITY, $urandom_range(0, 255));
            steady = ($urandom_range(0, 4) == 0);
            items = $urandom_range(20, 80);
            repeat (items) begin
                case ($urandom_range(0, 2))
                    0: cost = 8'($urandom_range(0, 255));
                    1: begin
                        lo = ((cost_lo < cost_hi) ? cost_lo : cost_hi) - 2;
                        hi = ((cost_lo < cost_hi) ? cost_hi : cost_lo) + 2;
                        if (lo < -128) lo = -128;
                        if (hi > 127) hi = 127;
                        cost = 8'(lo + $urandom_range(0, hi - lo));
                    end
                    default: begin
                        case ($urandom_range(0, 5))
                            0:       cost = 8'h80;
                            1:       cost = 8'hFF;
                            2:       cost = 8'h00;
                            3:       cost = 8'h7F;
                            4:       cost = 8'(cost_lo);
                            default: cost = 8'(cost_hi);
                        endcase
                    end
                endcase
                send_cell(cost);
                if ($urandom_range(0, 199) == 0) settle();
            end
            steady = 1'b0;
            sent += items;
        end
    endtask

    // Receiver stall pattern: random stretches of ready and not ready.
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_hold == 0) begin
            ready_next = ($urandom_range(0, 3) != 0);
            ready_hold = ready_next ? $urandom_range(1, 30) : $urandom_range(1, 10);
            m_ready <= ready_next;
        end else begin
            ready_hold--;
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                errors++;
                $display("%0t: result word expected none, got col %0d row %0d",
                         $time, m_cell_col, m_cell_row);
            end else begin
                want = pending_colors.pop_front();
                check_field("cell_col", want.col, m_cell_col);
                check_field("cell_row", want.row, m_cell_row);
                check_field("red", want.red, m_red);
                check_field("green", want.green, m_green);
                check_field("blue", want.blue, m_blue);
                check_field("alpha", want.alpha, m_alpha);
                check_field("is_unknown", want.unknown, m_is_unknown);
            end
        end
    end

    initial begin
        #8000000;
        $display("cost_grid_colormap_sampler verification failed");
        $finish;
    end

    initial begin
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cost = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        grid_w = 1;
        grid_h = 1;
        stride = 1;
        cost_lo = 0;
        cost_hi = 100;
        unknown_en = 1'b0;
        pastel = 1'b0;
        opacity = 8'd89;
        col_pos = 0;
        row_pos = 0;
        errors = 0;
        burst_left = 0;
        steady = 1'b0;
        ready_hold = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_palette_extremes();
        test_geometry_change();
        test_random_traffic();

        // Drain with a limit, then give the block time to show any stray word.
        s_valid <= 1'b0;
        waited = 0;
        while (pending_colors.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (errors == 0 && pending_colors.size() == 0) begin
            $display("cost_grid_colormap_sampler verification clean");
        end else begin
            $display("cost_grid_colormap_sampler verification failed");
        end
        $finish;
    end

endmodule
